@@ rtl/core/drpc_pkg.sv @@
// ----------------------------------------------------------------------------
// drpc_pkg
// Shared types and constants for the dual rotation period capture core.
// ----------------------------------------------------------------------------
package drpc_pkg;

  localparam int unsigned DATA_W = 32;

  // wrap period after reset: full 32-bit counter
  localparam logic [DATA_W-1:0] CPERIOD_RST = 32'hFFFF_FFFF;

  // event kind carried by each input transaction
  typedef enum logic [1:0] {
    ACT_CAPTURE_A = 2'd0,
    ACT_CAPTURE_B = 2'd1,
    ACT_OVERFLOW  = 2'd2
  } action_t;

  // per-channel tracking state
  typedef struct packed {
    logic [DATA_W-1:0] last;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] count;
    logic              pending;
  } chan_state_t;

  // per-channel event strobes
  typedef struct packed {
    logic capture;
    logic overflow;
  } chan_ctrl_t;

endpackage

@@ rtl/core/drpc_chan.sv @@
// ----------------------------------------------------------------------------
// drpc_chan
// Next-state logic for one sensor channel: period measurement on capture,
// stale detection on counter overflow.
// ----------------------------------------------------------------------------
module drpc_chan (
  input  drpc_pkg::chan_state_t        cur,
  input  drpc_pkg::chan_ctrl_t         ctrl,
  input  logic [drpc_pkg::DATA_W-1:0]  cap,
  input  logic [drpc_pkg::DATA_W-1:0]  counter_period,
  output drpc_pkg::chan_state_t        nxt
);
  import drpc_pkg::*;

  logic              wrapped;
  logic [DATA_W-1:0] period_wrap;
  logic [DATA_W-1:0] period_diff;

  // candidate periods, both modulo 2^32
  assign wrapped     = cur.pending && (cap < cur.last);
  assign period_wrap = (counter_period - cur.last) + cap;
  assign period_diff = cap - cur.last;

  // channel update
  always_comb begin
    nxt = cur;
    if (ctrl.capture) begin
      if (wrapped) begin
        nxt.period = period_wrap;
      end else if (cur.last != '0) begin
        nxt.period = period_diff;
      end
      nxt.last    = cap;
      nxt.pending = 1'b0;
      nxt.count   = cur.count + DATA_W'(1);
    end else if (ctrl.overflow) begin
      if (cur.pending) begin
        // second overflow without a capture: channel has gone stale
        nxt.last   = '0;
        nxt.count  = '0;
        nxt.period = '0;
      end else begin
        nxt.pending = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/dual_rotation_period_capture_core.sv @@
// ----------------------------------------------------------------------------
// dual_rotation_period_capture_core
// Two-channel rotation period and count tracker on a shared capture counter.
// ----------------------------------------------------------------------------
// Each input transaction is one event (capture on A, capture on B, or counter
// overflow) and yields exactly one result transaction carrying the channel
// counts, periods, pending-overflow flags and start time as they stand after
// that event. Events are taken into an input register, the state update is
// one pass of short logic, and the result is registered, so an event passes
// the input register and then the result register, and one event is accepted
// every cycle while the result side keeps up. The result register can hold a
// finished result while the next event waits in the input register.
// counter_period may only be written while no event is in flight.
module dual_rotation_period_capture_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [drpc_pkg::DATA_W-1:0]  cfg_wr_data,
  // event input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [drpc_pkg::DATA_W-1:0]  in_capture_value,
  input  logic [drpc_pkg::DATA_W-1:0]  in_now_ms,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [drpc_pkg::DATA_W-1:0]  out_rotations_a,
  output logic [drpc_pkg::DATA_W-1:0]  out_period_a,
  output logic [drpc_pkg::DATA_W-1:0]  out_rotations_b,
  output logic [drpc_pkg::DATA_W-1:0]  out_period_b,
  output logic [drpc_pkg::DATA_W-1:0]  out_start_ms,
  output logic                         out_overflow_pending_a,
  output logic                         out_overflow_pending_b
);
  import drpc_pkg::*;

  logic [DATA_W-1:0] counter_period_r;

  logic              s1_valid_r;
  logic [1:0]        s1_action_r;
  logic [DATA_W-1:0] s1_cap_r;
  logic [DATA_W-1:0] s1_now_r;

  logic              out_valid_r;
  logic              advance;
  logic              update;

  chan_state_t       chan_a_r, chan_a_nxt;
  chan_state_t       chan_b_r, chan_b_nxt;
  logic [DATA_W-1:0] start_r, start_nxt;
  chan_ctrl_t        ctrl_a, ctrl_b;

  // handshake: result slot frees when empty or being taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign update   = s1_valid_r && advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_period_r <= CPERIOD_RST;
    end else if (cfg_wr_en) begin
      counter_period_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_cap_r    <= in_capture_value;
      s1_now_r    <= in_now_ms;
    end
  end

  // event decode and start time update
  always_comb begin
    ctrl_a    = '0;
    ctrl_b    = '0;
    start_nxt = start_r;
    case (action_t'(s1_action_r))
      ACT_CAPTURE_A: begin
        ctrl_a.capture = 1'b1;
        if (start_r == '0) begin
          start_nxt = s1_now_r;
        end
      end
      ACT_CAPTURE_B: begin
        ctrl_b.capture = 1'b1;
        if (start_r == '0) begin
          start_nxt = s1_now_r;
        end
      end
      ACT_OVERFLOW: begin
        ctrl_a.overflow = 1'b1;
        ctrl_b.overflow = 1'b1;
        // both channels stale: measurement run is over
        if (chan_a_r.pending && chan_b_r.pending) begin
          start_nxt = '0;
        end
      end
      default: begin
        start_nxt = start_r;
      end
    endcase
  end

  // per-channel next state
  drpc_chan u_chan_a (
    .cur            (chan_a_r),
    .ctrl           (ctrl_a),
    .cap            (s1_cap_r),
    .counter_period (counter_period_r),
    .nxt            (chan_a_nxt)
  );

  drpc_chan u_chan_b (
    .cur            (chan_b_r),
    .ctrl           (ctrl_b),
    .cap            (s1_cap_r),
    .counter_period (counter_period_r),
    .nxt            (chan_b_nxt)
  );

  // state registers, which also serve as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_a_r <= '0;
      chan_b_r <= '0;
      start_r  <= '0;
    end else if (update) begin
      chan_a_r <= chan_a_nxt;
      chan_b_r <= chan_b_nxt;
      start_r  <= start_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_rotations_a        = chan_a_r.count;
  assign out_period_a           = chan_a_r.period;
  assign out_rotations_b        = chan_b_r.count;
  assign out_period_b           = chan_b_r.period;
  assign out_start_ms           = start_r;
  assign out_overflow_pending_a = chan_a_r.pending;
  assign out_overflow_pending_b = chan_b_r.pending;

endmodule

@@ rtl/core/drpc_checker.sv @@
// ----------------------------------------------------------------------------
// drpc_checker
// Port-level checks for the dual rotation period capture core.
// ----------------------------------------------------------------------------
module drpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [drpc_pkg::DATA_W-1:0]  out_rotations_a,
  input logic [drpc_pkg::DATA_W-1:0]  out_start_ms
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rotations_a)
      && $stable(out_start_ms))
    else $error("stalled result changed");

  // result fields only move together with a new result transaction
  a_fields_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (!$stable(out_rotations_a) || !$stable(out_start_ms))
      |-> out_valid)
    else $error("result fields changed without a transaction");

  // with the result slot empty the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

endmodule

bind dual_rotation_period_capture_core drpc_checker u_drpc_checker (.*);
